@@ sv/utf8_pkg.sv @@
`default_nettype none

package utf8_pkg;

  // Field widths.
  localparam int unsigned ByteW = 8;
  localparam int unsigned CpW   = 31;
  localparam int unsigned RemW  = 3;

  // Lead byte classes, tested from the longest prefix down.
  localparam logic [ByteW-1:0] Lead6Mask = 8'b1111_1100;
  localparam logic [ByteW-1:0] Lead5Mask = 8'b1111_1000;
  localparam logic [ByteW-1:0] Lead4Mask = 8'b1111_0000;
  localparam logic [ByteW-1:0] Lead3Mask = 8'b1110_0000;
  localparam logic [ByteW-1:0] Lead2Mask = 8'b1100_0000;
  localparam logic [ByteW-1:0] ContTag   = 8'b1000_0000;
  localparam logic [ByteW-1:0] ContMask  = 8'b0011_1111;

  // One input byte as held in the input register.
  typedef struct packed {
    logic             valid;
    logic [ByteW-1:0] data_byte;
    logic             last_byte;
  } byte_item_t;

  // Lead byte classification: continuation count and payload bits.
  typedef struct packed {
    logic [RemW-1:0] need;
    logic [4:0]      payload;
  } lead_info_t;

  function automatic lead_info_t classify_lead(logic [ByteW-1:0] b);
    lead_info_t info;
    info.need    = '0;
    info.payload = '0;
    if ((b & Lead6Mask) == Lead6Mask) begin
      info.need    = 3'd5;
      info.payload = {4'b0, b[0]};
    end else if ((b & Lead5Mask) == Lead5Mask) begin
      info.need    = 3'd4;
      info.payload = {3'b0, b[1:0]};
    end else if ((b & Lead4Mask) == Lead4Mask) begin
      info.need    = 3'd3;
      info.payload = {2'b0, b[2:0]};
    end else if ((b & Lead3Mask) == Lead3Mask) begin
      info.need    = 3'd2;
      info.payload = {1'b0, b[3:0]};
    end else if ((b & Lead2Mask) == Lead2Mask) begin
      info.need    = 3'd1;
      info.payload = b[4:0];
    end
    return info;
  endfunction

endpackage

`default_nettype wire

@@ sv/utf8_if.sv @@
`default_nettype none

// Byte stream channel.
interface utf8_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// Decoded code point channel.
interface utf8_cp_if;
  logic        valid;
  logic        ready;
  logic [30:0] code_point;
  logic        error;
  logic [7:0]  bad_byte;
  logic        truncated;

  modport source (output valid, output code_point, output error, output bad_byte,
                  output truncated, input ready);
  modport sink   (input valid, input code_point, input error, input bad_byte,
                  input truncated, output ready);
endinterface

`default_nettype wire

@@ sv/utf8_in_stage.sv @@
`default_nettype none

module utf8_in_stage (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  utf8_byte_if.sink                 in_i,
  input  wire logic                 adv_i,
  output utf8_pkg::byte_item_t      item_o
);
  import utf8_pkg::*;

  logic             vld_q, vld_d;
  logic [ByteW-1:0] byte_q;
  logic             last_q;
  logic             load;

  // The register takes a new transaction when empty or when it drains this cycle.
  assign in_i.ready = !vld_q || adv_i;
  assign load       = in_i.valid && in_i.ready;

  always_comb begin
    vld_d = vld_q;
    if (in_i.ready) begin
      vld_d = in_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= in_i.data_byte;
      last_q <= in_i.last_byte;
    end
  end

  assign item_o.valid     = vld_q;
  assign item_o.data_byte = byte_q;
  assign item_o.last_byte = last_q;

endmodule

`default_nettype wire

@@ sv/utf8_core.sv @@
`default_nettype none

module utf8_core (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire utf8_pkg::byte_item_t item_i,
  output logic                      adv_o,
  utf8_cp_if.source                 out_o
);
  import utf8_pkg::*;

  logic [RemW-1:0]  rem_q, rem_d;
  logic [CpW-1:0]   acc_q, acc_d;
  logic             res_vld_q, res_vld_d;
  logic [CpW-1:0]   cp_q, cp_d;
  logic             err_q, err_d;
  logic [ByteW-1:0] bad_q, bad_d;
  logic             trunc_q, trunc_d;
  logic             emit;
  logic             fire;
  logic [ByteW-1:0] b;
  lead_info_t       lead;
  logic [CpW-1:0]   acc_shift;
  logic [RemW-1:0]  rem_dec;

  // The result register moves when empty or when its transaction is taken.
  assign adv_o = !res_vld_q || out_o.ready;
  assign fire  = item_i.valid && adv_o;

  assign b         = item_i.data_byte;
  assign lead      = classify_lead(b);
  assign acc_shift = {acc_q[CpW-7:0], b[5:0]};
  assign rem_dec   = rem_q - 3'd1;

  // Decode step: state update and the result it causes.
  always_comb begin
    rem_d   = rem_q;
    acc_d   = acc_q;
    emit    = 1'b0;
    cp_d    = '0;
    err_d   = 1'b0;
    bad_d   = '0;
    trunc_d = 1'b0;
    if (rem_q == '0) begin
      if (lead.need == '0) begin
        // Plain byte or stray continuation passes through unchanged.
        emit = 1'b1;
        cp_d = {{(CpW-ByteW){1'b0}}, b};
      end else if (item_i.last_byte) begin
        emit    = 1'b1;
        cp_d    = {{(CpW-5){1'b0}}, lead.payload};
        trunc_d = 1'b1;
        acc_d   = '0;
      end else begin
        acc_d = {{(CpW-5){1'b0}}, lead.payload};
        rem_d = lead.need;
      end
    end else if ((b & Lead2Mask) != ContTag) begin
      // Malformed continuation aborts the sequence.
      emit  = 1'b1;
      err_d = 1'b1;
      bad_d = b;
      rem_d = '0;
      acc_d = '0;
    end else if (rem_dec == '0) begin
      emit  = 1'b1;
      cp_d  = acc_shift;
      rem_d = '0;
      acc_d = '0;
    end else if (item_i.last_byte) begin
      emit    = 1'b1;
      cp_d    = acc_shift;
      trunc_d = 1'b1;
      rem_d   = '0;
      acc_d   = '0;
    end else begin
      acc_d = acc_shift;
      rem_d = rem_dec;
    end
  end

  always_comb begin
    res_vld_d = res_vld_q;
    if (adv_o) begin
      res_vld_d = fire && emit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q     <= '0;
      acc_q     <= '0;
      res_vld_q <= 1'b0;
    end else begin
      res_vld_q <= res_vld_d;
      if (fire) begin
        rem_q <= rem_d;
        acc_q <= acc_d;
      end
    end
  end

  // Result payload is loaded only with a result.
  always_ff @(posedge clk_i) begin
    if (fire && emit) begin
      cp_q    <= cp_d;
      err_q   <= err_d;
      bad_q   <= bad_d;
      trunc_q <= trunc_d;
    end
  end

  assign out_o.valid      = res_vld_q;
  assign out_o.code_point = cp_q;
  assign out_o.error      = err_q;
  assign out_o.bad_byte   = bad_q;
  assign out_o.truncated  = trunc_q;

endmodule

`default_nettype wire

@@ sv/utf8_decoder_top.sv @@
// UTF-8 decoder, original form with sequences of up to six bytes.
// A byte that completes a symbol passes the input register and then the result register before its result shows.
// Throughput: one byte per cycle when not stalled, set by the input register and the result register.
// Each byte passes one decode step between them; backpressure stalls both registers.
// Reset: rst_ni is asynchronous, active low, and clears the sequence state and both valids.
`default_nettype none

module utf8_decoder_top (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  utf8_byte_if.sink in_i,
  utf8_cp_if.source out_o
);
  import utf8_pkg::*;

  byte_item_t item;
  logic       adv;

  // Input register.
  utf8_in_stage u_in_stage (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .adv_i  (adv),
    .item_o (item)
  );

  // Decode step and result register.
  utf8_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (item),
    .adv_o  (adv),
    .out_o  (out_o)
  );

endmodule

`default_nettype wire

@@ sv/utf8_decoder_chk.sv @@
`default_nettype none

module utf8_decoder_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [30:0] out_code_point_i,
  input wire logic        out_error_i,
  input wire logic [7:0]  out_bad_byte_i,
  input wire logic        out_truncated_i
);

  // A stalled result transaction stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result valid dropped while stalled");

  // An error result carries no code point and no truncation.
  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_error_i |-> out_code_point_i == '0 && !out_truncated_i)
    else $error("error result with code point or truncation");

  // The offending byte is reported only with an error.
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_error_i |-> out_bad_byte_i == '0)
    else $error("bad byte set without error");

  // A new result traces back to an input transaction through the input register and the result register.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i, 2))
    else $error("result appeared without a matching input transaction");

endmodule

bind utf8_decoder_top utf8_decoder_chk u_chk (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .out_code_point_i (out_o.code_point),
  .out_error_i      (out_o.error),
  .out_bad_byte_i   (out_o.bad_byte),
  .out_truncated_i  (out_o.truncated)
);

`default_nettype wire

@@ test/tb.sv @@
module tb;
  import utf8_pkg::*;

  // One decoded symbol as it leaves the block.
  typedef struct packed {
    logic [CpW-1:0]   code_point;
    logic             error;
    logic [ByteW-1:0] bad_byte;
    logic             truncated;
  } cp_result_t;

  // One row of the directed byte stream; typed rows carry their known result.
  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             last_byte;
    logic             typed;
    cp_result_t       want;
  } byte_row_t;

  localparam int unsigned NumRows    = 25;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DrainWait  = 8;
  localparam cp_result_t  NoCp       = '0;

  localparam byte_row_t ByteRows [NumRows] = '{
    '{8'h00, 1'b0, 1'b1, '{31'h0000_0000, 1'b0, 8'h00, 1'b0}},
    '{8'h80, 1'b0, 1'b1, '{31'h0000_0080, 1'b0, 8'h00, 1'b0}},
    '{8'hC3, 1'b0, 1'b0, NoCp},
    '{8'hA9, 1'b0, 1'b0, NoCp},
    '{8'hE2, 1'b0, 1'b0, NoCp},
    '{8'h82, 1'b0, 1'b0, NoCp},
    '{8'hAC, 1'b0, 1'b0, NoCp},
    '{8'hF8, 1'b0, 1'b0, NoCp},
    '{8'h88, 1'b0, 1'b0, NoCp},
    '{8'h80, 1'b0, 1'b0, NoCp},
    '{8'h80, 1'b0, 1'b0, NoCp},
    '{8'h80, 1'b0, 1'b0, NoCp},
    '{8'hFF, 1'b0, 1'b0, NoCp},
    '{8'hBF, 1'b0, 1'b0, NoCp},
    '{8'hBF, 1'b0, 1'b0, NoCp},
    '{8'hBF, 1'b0, 1'b0, NoCp},
    '{8'hBF, 1'b0, 1'b0, NoCp},
    '{8'hBF, 1'b0, 1'b1, '{31'h7FFF_FFFF, 1'b0, 8'h00, 1'b0}},
    '{8'hC0, 1'b0, 1'b0, NoCp},
    '{8'h41, 1'b0, 1'b1, '{31'h0000_0000, 1'b1, 8'h41, 1'b0}},
    '{8'hFE, 1'b1, 1'b1, '{31'h0000_0000, 1'b0, 8'h00, 1'b1}},
    '{8'hE1, 1'b0, 1'b0, NoCp},
    '{8'h80, 1'b1, 1'b0, NoCp},
    '{8'hDF, 1'b0, 1'b0, NoCp},
    '{8'hFF, 1'b1, 1'b1, '{31'h0000_0000, 1'b1, 8'hFF, 1'b0}}
  };

  logic clk;
  logic rst_n;

  utf8_byte_if byte_ch ();
  utf8_cp_if   cp_ch ();

  utf8_decoder_top uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (byte_ch),
    .out_o (cp_ch)
  );

  // Decoder shadow state and the symbols still owed by the block.
  logic [RemW-1:0] seq_left = '0;
  logic [CpW-1:0]  seq_acc  = '0;
  cp_result_t      pending_cps [$];

  int unsigned src_idle_pct  = 32;
  int unsigned sink_idle_pct = 80;
  int unsigned bytes_sent    = 0;
  int unsigned mismatches    = 0;
  int unsigned cycle_cnt     = 0;

  // The clock starts low so the first rising edge comes after the initial block waits on it.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Run the byte through the shadow decoder; returns 1 when a symbol comes out.
  function automatic bit decode_byte(input logic [ByteW-1:0] b, input logic lst,
                                     output cp_result_t res);
    logic [RemW-1:0] need;
    logic [4:0]      payload;
    res     = '0;
    need    = '0;
    payload = '0;
    if (seq_left == '0) begin
      casez (b)
        8'b1111_11??: begin need = 3'd5; payload = {4'b0, b[0]};   end
        8'b1111_10??: begin need = 3'd4; payload = {3'b0, b[1:0]}; end
        8'b1111_0???: begin need = 3'd3; payload = {2'b0, b[2:0]}; end
        8'b1110_????: begin need = 3'd2; payload = {1'b0, b[3:0]}; end
        8'b110?_????: begin need = 3'd1; payload = b[4:0];         end
        default: begin
          // Plain ASCII or a stray continuation goes straight through.
          res.code_point = {23'b0, b};
          return 1'b1;
        end
      endcase
      if (lst) begin
        res.code_point = {26'b0, payload};
        res.truncated  = 1'b1;
        seq_acc        = '0;
        return 1'b1;
      end
      seq_acc  = {26'b0, payload};
      seq_left = need;
      return 1'b0;
    end
    // Inside a sequence every byte must look like 10xxxxxx.
    if (b[7:6] != 2'b10) begin
      seq_left     = '0;
      seq_acc      = '0;
      res.error    = 1'b1;
      res.bad_byte = b;
      return 1'b1;
    end
    seq_acc  = {seq_acc[24:0], b[5:0]};
    seq_left = seq_left - 1'b1;
    if (seq_left == '0) begin
      res.code_point = seq_acc;
      seq_acc        = '0;
      return 1'b1;
    end
    if (lst) begin
      res.code_point = seq_acc;
      res.truncated  = 1'b1;
      seq_left       = '0;
      seq_acc        = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Offer one byte, wait for its transaction, then record what it should produce.
  task automatic send_byte(input logic [ByteW-1:0] b, input logic lst,
                           input logic use_typed, input cp_result_t typed_res);
    cp_result_t res;
    bit         has_cp;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      byte_ch.valid <= 1'b0;
      @(posedge clk);
    end
    byte_ch.valid     <= 1'b1;
    byte_ch.data_byte <= b;
    byte_ch.last_byte <= lst;
    do @(posedge clk); while (!byte_ch.ready);
    bytes_sent++;
    has_cp = decode_byte(b, lst, res);
    if (use_typed) begin
      pending_cps.push_back(typed_res);
    end else if (has_cp) begin
      pending_cps.push_back(res);
    end
  endtask

  // Hold the stream off until every owed symbol has been delivered.
  task automatic hold_until_drained();
    byte_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_cps.size() != 0);
  endtask

  // Mostly well-formed symbols with random payload; some noise, cut-off
  // sequences and sequences broken by a bad continuation byte.
  task automatic send_symbol();
    logic [ByteW-1:0] seq [$];
    int unsigned      kind;
    int unsigned      len;
    int unsigned      stop_at;
    int unsigned      pfx;
    bit               cut;
    bit               end_flag;
    kind = $urandom_range(0, 99);
    if (kind < 12) begin
      send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0, NoCp);
      return;
    end
    len = $urandom_range(1, 6);
    case (len)
      1: begin
        if ($urandom_range(0, 3) == 0) seq.push_back(8'($urandom_range(8'h80, 8'hBF)));
        else seq.push_back(8'($urandom_range(8'h00, 8'h7F)));
      end
      2: seq.push_back({3'b110, 5'($urandom)});
      3: seq.push_back({4'b1110, 4'($urandom)});
      4: seq.push_back({5'b11110, 3'($urandom)});
      5: seq.push_back({6'b111110, 2'($urandom)});
      default: seq.push_back({6'b111111, 2'($urandom)});
    endcase
    for (int i = 1; i < len; i++) seq.push_back({2'b10, 6'($urandom)});
    stop_at  = len - 1;
    cut      = 1'b0;
    end_flag = ($urandom_range(0, 3) == 0);
    if (len > 1 && kind < 24) begin
      // Stream ends inside the sequence.
      stop_at = $urandom_range(0, len - 2);
      cut     = 1'b1;
    end else if (len > 1 && kind < 36) begin
      // A continuation slot gets a byte of the wrong form.
      stop_at      = $urandom_range(1, len - 1);
      pfx          = $urandom_range(0, 2);
      seq[stop_at] = {(pfx == 2) ? 2'b11 : 2'(pfx), 6'($urandom)};
    end
    for (int i = 0; i <= stop_at; i++) begin
      send_byte(seq[i], (i == stop_at) && (cut || end_flag), 1'b0, NoCp);
    end
    if ($urandom_range(0, 99) == 0) hold_until_drained();
  endtask

  // Result side: check each transaction, then pick the next ready at random.
  always @(posedge clk) begin : cp_monitor
    cp_result_t want;
    if (cp_ch.valid && cp_ch.ready) begin
      if (pending_cps.size() == 0) begin
        $display("%0t: unexpected symbol code_point %h error %b bad_byte %h truncated %b",
                 $time, cp_ch.code_point, cp_ch.error, cp_ch.bad_byte, cp_ch.truncated);
        mismatches++;
      end else begin
        want = pending_cps.pop_front();
        if (cp_ch.code_point !== want.code_point) begin
          $display("%0t: code_point expected %h, got %h", $time, want.code_point,
                   cp_ch.code_point);
          mismatches++;
        end
        if (cp_ch.error !== want.error) begin
          $display("%0t: error expected %b, got %b", $time, want.error, cp_ch.error);
          mismatches++;
        end
        if (cp_ch.bad_byte !== want.bad_byte) begin
          $display("%0t: bad_byte expected %h, got %h", $time, want.bad_byte, cp_ch.bad_byte);
          mismatches++;
        end
        if (cp_ch.truncated !== want.truncated) begin
          $display("%0t: truncated expected %b, got %b", $time, want.truncated,
                   cp_ch.truncated);
          mismatches++;
        end
      end
    end
    cp_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("FAIL utf8_decoder_top");
      $finish;
    end
  end

  initial begin
    rst_n             = 1'b0;
    byte_ch.valid     = 1'b0;
    byte_ch.data_byte = '0;
    byte_ch.last_byte = 1'b0;
    cp_ch.ready       = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed stream: extremes, lead classes of two, three, five and six bytes, errors and truncation.
    for (int i = 0; i < NumRows; i++) begin
      send_byte(ByteRows[i].data_byte, ByteRows[i].last_byte, ByteRows[i].typed,
                ByteRows[i].want);
    end

    // Random stream in three idling phases.
    while (bytes_sent < 200) send_symbol();
    hold_until_drained();
    src_idle_pct  = 80;
    sink_idle_pct = 32;
    while (bytes_sent < 400) send_symbol();
    hold_until_drained();
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    while (bytes_sent < 625) send_symbol();

    byte_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_cps.size() != 0);
    repeat (DrainWait) @(posedge clk);
    if (pending_cps.size() != 0) begin
      $display("%0t: %0d symbols never arrived", $time, pending_cps.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("PASS utf8_decoder_top");
    end else begin
      $display("FAIL utf8_decoder_top");
    end
    $finish;
  end

endmodule
